[hdl/eeu_pkg.sv]
package eeu_pkg;

    // Instruction opcodes, bits 15..12 of the instruction word.
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_LDI  = 4'd3;
    localparam logic [3:0] OP_BEQZ = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_JR   = 4'd7;
    localparam logic [3:0] OP_SLC  = 4'd8;
    localparam logic [3:0] OP_SRC  = 4'd9;
    localparam logic [3:0] OP_LB   = 4'd10;
    localparam logic [3:0] OP_SB   = 4'd11;

    // Bit positions in the status flag field.
    localparam int FLAG_C = 4;
    localparam int FLAG_V = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_S = 1;
    localparam int FLAG_Z = 0;

    localparam int REG_COUNT  = 64;
    localparam int REG_IDX_W  = 6;
    localparam int DATA_W     = 8;
    localparam int PC_W       = 16;
    localparam int FLAGS_W    = 5;
    // Byte addresses reachable by LB and SB.
    localparam int MEM_SPAN   = 256;
    localparam int MEM_ADDR_W = 8;
    localparam int DATA_DEPTH = 2048;

    localparam logic [DATA_W-1:0] IMM_EXT_MASK = 8'b1100_0000;

    typedef struct packed {
        logic [3:0]           op;
        logic [REG_IDX_W-1:0] ra;
        logic [REG_IDX_W-1:0] rb;
        logic [PC_W-1:0]      addr;
    } t_instr;

    typedef struct packed {
        logic [PC_W-1:0]       next_pc;
        logic                  taken;
        logic [FLAGS_W-1:0]    flags;
        logic                  rw;
        logic [REG_IDX_W-1:0]  ridx;
        logic [DATA_W-1:0]     rval;
        logic                  mw;
        logic [MEM_ADDR_W-1:0] maddr;
        logic [DATA_W-1:0]     mval;
    } t_result;

endpackage

[hdl/eight_bit_isa_execute_unit.sv]
// An accepted request and its operand reads are registered in r_s1, its result in r_out.
// Throughput: one instruction per cycle unless i_out_stall holds the output; register file
// and data memory writes are forwarded to the next instruction; dependencies never stall.
// Reset: all registers and all data bytes read as zero after reset, through per-entry
// valid bits, so no clearing pass is needed and requests are taken right away.
module eight_bit_isa_execute_unit #(
    parameter int DATA_DEPTH = eeu_pkg::DATA_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_instr_word,
    input  logic [15:0] i_instr_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_next_pc,
    output logic        o_branch_taken,
    output logic [4:0]  o_status_flags,
    output logic        o_reg_written,
    output logic [5:0]  o_reg_index,
    output logic [7:0]  o_reg_value,
    output logic        o_mem_written,
    output logic [7:0]  o_mem_address,
    output logic [7:0]  o_mem_value
);

    localparam int DAW = $clog2(DATA_DEPTH);

    logic                                 accept;
    logic                                 s1_fire;
    logic [eeu_pkg::REG_IDX_W-1:0]        in_ra;
    logic [eeu_pkg::REG_IDX_W-1:0]        in_rb;
    logic [eeu_pkg::MEM_ADDR_W-1:0]       in_imm8;

    logic                                 r_s1_valid;
    eeu_pkg::t_instr                      r_s1;
    logic                                 r_a_vld;
    logic                                 r_b_vld;
    logic                                 r_d_vld;
    logic [eeu_pkg::REG_COUNT-1:0]        r_reg_vld;
    logic [eeu_pkg::MEM_SPAN-1:0]         r_mem_vld;

    // Last register and memory writes, forwarded to the instruction behind.
    logic                                 r_rw_valid;
    logic [eeu_pkg::REG_IDX_W-1:0]        r_rw_idx;
    logic [eeu_pkg::DATA_W-1:0]           r_rw_val;
    logic                                 r_mw_valid;
    logic [eeu_pkg::MEM_ADDR_W-1:0]       r_mw_addr;
    logic [eeu_pkg::DATA_W-1:0]           r_mw_val;

    logic [eeu_pkg::DATA_W-1:0]           rd_a;
    logic [eeu_pkg::DATA_W-1:0]           rd_b;
    logic [eeu_pkg::DATA_W-1:0]           rd_d;
    logic [eeu_pkg::DATA_W-1:0]           op_a;
    logic [eeu_pkg::DATA_W-1:0]           op_b;
    logic [eeu_pkg::DATA_W-1:0]           op_d;
    eeu_pkg::t_result                     res;

    logic                                 r_out_valid;
    eeu_pkg::t_result                     r_out;

    assign in_ra   = i_instr_word[11:6];
    assign in_rb   = i_instr_word[5:0];
    assign in_imm8 = {{2{i_instr_word[5]}}, i_instr_word[5:0]};

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign accept     = i_in_valid && !o_in_stall;

    eeu_ram #(.WIDTH(eeu_pkg::DATA_W), .DEPTH(eeu_pkg::REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (s1_fire && res.rw),
        .i_waddr (r_s1.ra),
        .i_wdata (res.rval),
        .i_re    (accept),
        .i_raddr (in_ra),
        .o_rdata (rd_a)
    );

    eeu_ram #(.WIDTH(eeu_pkg::DATA_W), .DEPTH(eeu_pkg::REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (s1_fire && res.rw),
        .i_waddr (r_s1.ra),
        .i_wdata (res.rval),
        .i_re    (accept),
        .i_raddr (in_rb),
        .o_rdata (rd_b)
    );

    eeu_ram #(.WIDTH(eeu_pkg::DATA_W), .DEPTH(DATA_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (s1_fire && res.mw),
        .i_waddr (DAW'(res.maddr)),
        .i_wdata (res.mval),
        .i_re    (accept),
        .i_raddr (DAW'(in_imm8)),
        .o_rdata (rd_d)
    );

    // The most recent write is either the one that raced this instruction's read
    // or one already held in the memory, so forwarding it is always correct.
    always_comb begin
        op_a = r_a_vld ? rd_a : '0;
        op_b = r_b_vld ? rd_b : '0;
        op_d = r_d_vld ? rd_d : '0;
        if (r_rw_valid && r_rw_idx == r_s1.ra) begin
            op_a = r_rw_val;
        end
        if (r_rw_valid && r_rw_idx == r_s1.rb) begin
            op_b = r_rw_val;
        end
        if (r_mw_valid && r_mw_addr == {{2{r_s1.rb[5]}}, r_s1.rb}) begin
            op_d = r_mw_val;
        end
    end

    eeu_alu u_alu (
        .i_instr (r_s1),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_load  (op_d),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rw_valid  <= 1'b0;
            r_mw_valid  <= 1'b0;
            r_reg_vld   <= '0;
            r_mem_vld   <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire && res.rw) begin
                r_rw_valid         <= 1'b1;
                r_reg_vld[r_s1.ra] <= 1'b1;
            end
            if (s1_fire && res.mw) begin
                r_mw_valid           <= 1'b1;
                r_mem_vld[res.maddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.op   <= i_instr_word[15:12];
            r_s1.ra   <= in_ra;
            r_s1.rb   <= in_rb;
            r_s1.addr <= i_instr_addr;
            r_a_vld   <= r_reg_vld[in_ra];
            r_b_vld   <= r_reg_vld[in_rb];
            r_d_vld   <= r_mem_vld[in_imm8];
        end
        if (s1_fire) begin
            r_out <= res;
            if (res.rw) begin
                r_rw_idx <= r_s1.ra;
                r_rw_val <= res.rval;
            end
            if (res.mw) begin
                r_mw_addr <= res.maddr;
                r_mw_val  <= res.mval;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_pc      = r_out.next_pc;
    assign o_branch_taken = r_out.taken;
    assign o_status_flags = r_out.flags;
    assign o_reg_written  = r_out.rw;
    assign o_reg_index    = r_out.ridx;
    assign o_reg_value    = r_out.rval;
    assign o_mem_written  = r_out.mw;
    assign o_mem_address  = r_out.maddr;
    assign o_mem_value    = r_out.mval;

endmodule

[hdl/eeu_ram.sv]
module eeu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/eeu_alu.sv]
module eeu_alu (
    input  eeu_pkg::t_instr                   i_instr,
    input  logic [eeu_pkg::DATA_W-1:0]        i_a,
    input  logic [eeu_pkg::DATA_W-1:0]        i_b,
    input  logic [eeu_pkg::DATA_W-1:0]        i_load,
    output eeu_pkg::t_result                  o_res
);

    logic [eeu_pkg::DATA_W-1:0]   imm8;
    logic [eeu_pkg::DATA_W:0]     sum9;
    logic [eeu_pkg::DATA_W:0]     diff9;
    logic [2*eeu_pkg::DATA_W-1:0] prod;
    logic [2*eeu_pkg::DATA_W-1:0] rot_l;
    logic [2*eeu_pkg::DATA_W-1:0] rot_r;
    logic [eeu_pkg::PC_W-1:0]     pc_inc;
    logic [eeu_pkg::DATA_W-1:0]   r;
    logic                         nz_en;
    logic                         v;

    assign imm8   = i_instr.rb[5] ? ({2'b00, i_instr.rb} | eeu_pkg::IMM_EXT_MASK)
                                  : {2'b00, i_instr.rb};
    assign sum9   = {1'b0, i_a} + {1'b0, i_b};
    assign diff9  = {1'b0, i_a} - {1'b0, i_b};
    assign prod   = {8'd0, i_a} * {8'd0, i_b};
    assign rot_l  = {i_a, i_a} << i_instr.rb[2:0];
    assign rot_r  = {i_a, i_a} >> i_instr.rb[2:0];
    assign pc_inc = i_instr.addr + 16'd1;

    always_comb begin
        o_res         = '0;
        o_res.next_pc = pc_inc;
        r             = '0;
        nz_en         = 1'b0;
        v             = 1'b0;
        case (i_instr.op)
            eeu_pkg::OP_ADD: begin
                r     = sum9[7:0];
                nz_en = 1'b1;
                v     = sum9[8] ^ sum9[7] ^ i_a[7] ^ i_b[7];
                o_res.rw                    = 1'b1;
                o_res.flags[eeu_pkg::FLAG_C] = sum9[8];
                o_res.flags[eeu_pkg::FLAG_V] = v;
                o_res.flags[eeu_pkg::FLAG_S] = sum9[7] ^ v;
            end
            eeu_pkg::OP_SUB: begin
                r     = diff9[7:0];
                nz_en = 1'b1;
                v     = diff9[8] ^ diff9[7] ^ i_a[7] ^ i_b[7];
                o_res.rw                    = 1'b1;
                o_res.flags[eeu_pkg::FLAG_V] = v;
                o_res.flags[eeu_pkg::FLAG_S] = diff9[7] ^ v;
            end
            eeu_pkg::OP_MUL: begin
                r        = prod[7:0];
                nz_en    = 1'b1;
                o_res.rw = 1'b1;
            end
            eeu_pkg::OP_LDI: begin
                r        = imm8;
                o_res.rw = 1'b1;
            end
            eeu_pkg::OP_BEQZ: begin
                if (i_a == 8'd0) begin
                    o_res.next_pc = pc_inc + {{8{imm8[7]}}, imm8};
                    o_res.taken   = 1'b1;
                end
            end
            eeu_pkg::OP_AND: begin
                r        = i_a & i_b;
                nz_en    = 1'b1;
                o_res.rw = 1'b1;
            end
            eeu_pkg::OP_OR: begin
                r        = i_a | i_b;
                nz_en    = 1'b1;
                o_res.rw = 1'b1;
            end
            eeu_pkg::OP_JR: begin
                o_res.next_pc = {i_a, i_b};
                o_res.taken   = 1'b1;
            end
            eeu_pkg::OP_SLC: begin
                r        = rot_l[15:8];
                nz_en    = 1'b1;
                o_res.rw = 1'b1;
            end
            eeu_pkg::OP_SRC: begin
                r        = rot_r[7:0];
                nz_en    = 1'b1;
                o_res.rw = 1'b1;
            end
            eeu_pkg::OP_LB: begin
                r           = i_load;
                o_res.rw    = 1'b1;
                o_res.maddr = imm8;
            end
            eeu_pkg::OP_SB: begin
                o_res.mw    = 1'b1;
                o_res.maddr = imm8;
                o_res.mval  = i_a;
            end
            default: begin
            end
        endcase
        if (nz_en) begin
            o_res.flags[eeu_pkg::FLAG_N] = r[7];
            o_res.flags[eeu_pkg::FLAG_Z] = (r == 8'd0);
        end
        if (o_res.rw) begin
            o_res.ridx = i_instr.ra;
            o_res.rval = r;
        end
    end

endmodule
